// File: sv/spwh_pkg.sv
// Shared types, constants and helper functions of the strip pair hit histogram.
package spwh_pkg;

  localparam int STRIPS      = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int STRIP_W     = $clog2(STRIPS);
  localparam int BINS        = STRIPS * STRIPS;
  localparam int PAIR_W      = $clog2(BINS);

  localparam logic [15:0] FRONT_LOW_RST  = 16'd800;
  localparam logic [15:0] FRONT_HIGH_RST = 16'd3000;
  localparam logic [15:0] BACK_LOW_RST   = 16'd600;
  localparam logic [15:0] BACK_HIGH_RST  = 16'd3000;

  typedef logic [1:0]             func_t;
  typedef logic [1:0]             kind_t;
  typedef logic [1:0]             cfg_idx_t;
  typedef logic [STRIPS-1:0]      hits_t;
  typedef logic [STRIP_W-1:0]     strip_idx_t;
  typedef logic [PAIR_W-1:0]      pair_addr_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam func_t FUNC_SAMPLE = 2'd0;
  localparam func_t FUNC_READ   = 2'd1;
  localparam func_t FUNC_CLEAR  = 2'd2;

  localparam kind_t KIND_SAMPLE = 2'd0;
  localparam kind_t KIND_READ   = 2'd1;
  localparam kind_t KIND_CLEAR  = 2'd2;

  localparam cfg_idx_t REG_FRONT_LOW  = 2'd0;
  localparam cfg_idx_t REG_FRONT_HIGH = 2'd1;
  localparam cfg_idx_t REG_BACK_LOW   = 2'd2;
  localparam cfg_idx_t REG_BACK_HIGH  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Command bundle from the sequencer to the count map.
  typedef struct packed {
    logic       rd_en;
    pair_addr_t rd_addr;
    logic       inc_en;
    pair_addr_t inc_addr;
    logic       clr;
  } map_cmd_t;

  function automatic pair_addr_t pair_addr(strip_idx_t f, strip_idx_t b);
    return pair_addr_t'(int'(f) * STRIPS + int'(b));
  endfunction

  function automatic logic [31:0] clamp_bin(count_t c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

endpackage

// File: sv/spwh_ifs.sv
// Handshake channel interfaces: input items, result items and register writes.
interface spwh_in_if;
  logic                valid;
  logic                ready;
  spwh_pkg::func_t     func;
  logic                side;
  logic [3:0]          strip;
  logic [15:0]         amplitude;
  logic                event_end;
  logic [3:0]          read_front;
  logic [3:0]          read_back;

  modport source(output valid, func, side, strip, amplitude, event_end, read_front,
                 read_back, input ready);
  modport sink(input valid, func, side, strip, amplitude, event_end, read_front,
               read_back, output ready);
endinterface

interface spwh_out_if;
  logic            valid;
  logic            ready;
  spwh_pkg::kind_t kind;
  logic [31:0]     bin_count;
  logic [8:0]      event_pairs;

  modport source(output valid, kind, bin_count, event_pairs, input ready);
  modport sink(input valid, kind, bin_count, event_pairs, output ready);
endinterface

interface spwh_cfg_if;
  logic               valid;
  logic               ready;
  spwh_pkg::cfg_idx_t idx;
  logic [15:0]        data;

  modport source(output valid, idx, data, input ready);
  modport sink(input valid, idx, data, output ready);
endinterface

// File: sv/spwh_count_map.sv
// Bin count memory with per-bin valid bits and the shared saturating incrementer.
module spwh_count_map (
  input  logic               clk,
  input  logic               rst_n,
  input  spwh_pkg::map_cmd_t cmd,
  output spwh_pkg::count_t   rd_count
);
  import spwh_pkg::*;

  count_t mem [BINS];
  logic   vld_r [BINS];
  count_t rd_data_r;
  logic   rd_vld_r;
  count_t inc_val;

  assign rd_count = rd_vld_r ? rd_data_r : '0;

  // Saturating increment of the bin read in the previous cycle.
  assign inc_val = (rd_count == {COUNT_WIDTH{1'b1}}) ? rd_count : rd_count + count_t'(1);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
    if (cmd.inc_en) begin
      mem[cmd.inc_addr] <= inc_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BINS; i++) vld_r[i] <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        for (int i = 0; i < BINS; i++) vld_r[i] <= 1'b0;
      end else if (cmd.inc_en) begin
        vld_r[cmd.inc_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld_r <= vld_r[cmd.rd_addr];
      end
    end
  end

  a_inc_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.inc_en |-> $past(cmd.rd_en) && cmd.inc_addr == $past(cmd.rd_addr))
    else $error("increment without a matching read one cycle before");

  a_no_clear_during_inc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> !cmd.inc_en && !cmd.rd_en)
    else $error("clear overlaps a count access");

endmodule

// File: sv/strip_pair_window_hit_histogram_unit.sv
// Top level: strip hit capture, event close sequencer and result register.
// Flow: an accepted sample, read or clear goes from idle to the done state, which
// loads its result once the output slot is free; a sample with event_end first
// walks all STRIPS*STRIPS bins, one per cycle, then passes the drain state.
// Throughput: one item at a time; the next is taken once the result is loaded.
// Reset (synchronous, rst_n low): registers to defaults, hit bits cleared, count map
// cleared at once through per-bin valid bits; no clearing pass.
module strip_pair_window_hit_histogram_unit (
  input logic clk,
  input logic rst_n,
  spwh_in_if.sink    in_if,
  spwh_out_if.source out_if,
  spwh_cfg_if.sink   cfg_if
);
  import spwh_pkg::*;

  state_t      state_r, state_nxt;
  logic [15:0] front_lo_r, front_hi_r, back_lo_r, back_hi_r;
  hits_t       front_hits_r, front_hits_nxt, back_hits_r, back_hits_nxt;
  strip_idx_t  f_r, f_nxt, b_r, b_nxt;
  logic        p1_hit_r, p1_hit_nxt;
  pair_addr_t  p1_addr_r, p1_addr_nxt;
  logic [8:0]  pairs_r, pairs_nxt;
  kind_t       stg_kind_r, stg_kind_nxt;
  logic        stg_oor_r, stg_oor_nxt;
  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r, out_kind_nxt;
  logic [31:0] out_bin_r, out_bin_nxt;
  logic [8:0]  out_pairs_r, out_pairs_nxt;

  map_cmd_t    map_cmd;
  count_t      rd_count;

  logic        in_acc, slot_free, walk_hit, walk_last, strip_ok, amp_hit;
  hits_t       strip_mask;

  spwh_count_map u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (map_cmd),
    .rd_count (rd_count)
  );

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && in_if.ready;
  assign slot_free    = !out_valid_r || out_if.ready;

  assign out_if.valid       = out_valid_r;
  assign out_if.kind        = out_kind_r;
  assign out_if.bin_count   = out_bin_r;
  assign out_if.event_pairs = out_pairs_r;

  assign walk_hit   = front_hits_r[f_r] && back_hits_r[b_r];
  assign walk_last  = (f_r == strip_idx_t'(STRIPS - 1)) && (b_r == strip_idx_t'(STRIPS - 1));
  assign strip_ok   = (32'(in_if.strip) < 32'(STRIPS));
  assign strip_mask = hits_t'(1) << in_if.strip;
  assign amp_hit    = in_if.side ?
                      (in_if.amplitude > back_lo_r && in_if.amplitude < back_hi_r) :
                      (in_if.amplitude > front_lo_r && in_if.amplitude < front_hi_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_if.func == FUNC_SAMPLE && in_if.event_end) state_nxt = ST_WALK;
          else state_nxt = ST_DONE;
        end
      end
      ST_WALK: begin
        if (walk_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Count map commands.
  always_comb begin
    map_cmd          = '0;
    map_cmd.inc_en   = p1_hit_r;
    map_cmd.inc_addr = p1_addr_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_if.func == FUNC_READ) begin
          map_cmd.rd_en   = 1'b1;
          map_cmd.rd_addr = pair_addr(strip_idx_t'(in_if.read_front),
                                      strip_idx_t'(in_if.read_back));
        end
        if (in_acc && in_if.func == FUNC_CLEAR) map_cmd.clr = 1'b1;
      end
      ST_WALK: begin
        map_cmd.rd_en   = walk_hit;
        map_cmd.rd_addr = pair_addr(f_r, b_r);
      end
      default: ;
    endcase
  end

  // Datapath next values.
  always_comb begin
    front_hits_nxt = front_hits_r;
    back_hits_nxt  = back_hits_r;
    f_nxt          = f_r;
    b_nxt          = b_r;
    p1_hit_nxt     = 1'b0;
    p1_addr_nxt    = p1_addr_r;
    pairs_nxt      = pairs_r;
    stg_kind_nxt   = stg_kind_r;
    stg_oor_nxt    = stg_oor_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_kind_nxt   = out_kind_r;
    out_bin_nxt    = out_bin_r;
    out_pairs_nxt  = out_pairs_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pairs_nxt    = '0;
          f_nxt        = '0;
          b_nxt        = '0;
          stg_oor_nxt  = 1'b0;
          stg_kind_nxt = KIND_SAMPLE;
          case (in_if.func)
            FUNC_SAMPLE: begin
              if (strip_ok) begin
                if (in_if.side) begin
                  back_hits_nxt = amp_hit ? (back_hits_r | strip_mask)
                                          : (back_hits_r & ~strip_mask);
                end else begin
                  front_hits_nxt = amp_hit ? (front_hits_r | strip_mask)
                                           : (front_hits_r & ~strip_mask);
                end
              end
            end
            FUNC_READ: begin
              stg_kind_nxt = KIND_READ;
              stg_oor_nxt  = !((32'(in_if.read_front) < 32'(STRIPS)) &&
                               (32'(in_if.read_back) < 32'(STRIPS)));
            end
            FUNC_CLEAR: stg_kind_nxt = KIND_CLEAR;
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        p1_hit_nxt  = walk_hit;
        p1_addr_nxt = pair_addr(f_r, b_r);
        pairs_nxt   = pairs_r + 9'(walk_hit);
        if (b_r == strip_idx_t'(STRIPS - 1)) begin
          b_nxt = '0;
          f_nxt = f_r + strip_idx_t'(1);
        end else begin
          b_nxt = b_r + strip_idx_t'(1);
        end
      end
      ST_DRAIN: begin
        front_hits_nxt = '0;
        back_hits_nxt  = '0;
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = stg_kind_r;
          out_bin_nxt   = (stg_kind_r == KIND_READ && !stg_oor_r) ? clamp_bin(rd_count) : '0;
          out_pairs_nxt = pairs_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      front_hits_r <= '0;
      back_hits_r  <= '0;
      p1_hit_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      front_lo_r   <= FRONT_LOW_RST;
      front_hi_r   <= FRONT_HIGH_RST;
      back_lo_r    <= BACK_LOW_RST;
      back_hi_r    <= BACK_HIGH_RST;
    end else begin
      state_r      <= state_nxt;
      front_hits_r <= front_hits_nxt;
      back_hits_r  <= back_hits_nxt;
      p1_hit_r     <= p1_hit_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.idx)
          REG_FRONT_LOW:  front_lo_r <= cfg_if.data;
          REG_FRONT_HIGH: front_hi_r <= cfg_if.data;
          REG_BACK_LOW:   back_lo_r  <= cfg_if.data;
          REG_BACK_HIGH:  back_hi_r  <= cfg_if.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    f_r         <= f_nxt;
    b_r         <= b_nxt;
    p1_addr_r   <= p1_addr_nxt;
    pairs_r     <= pairs_nxt;
    stg_kind_r  <= stg_kind_nxt;
    stg_oor_r   <= stg_oor_nxt;
    out_kind_r  <= out_kind_nxt;
    out_bin_r   <= out_bin_nxt;
    out_pairs_r <= out_pairs_nxt;
  end

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside the done state");

  a_walk_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |=> state_r == ST_WALK || state_r == ST_DRAIN)
    else $error("bin walk left early");

  a_hits_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == ST_DRAIN) |-> front_hits_r == '0 && back_hits_r == '0)
    else $error("hit bits survive event close");

  a_no_inc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !p1_hit_r)
    else $error("count increment pending while idle");

endmodule
